### design/pldf_pkg.sv
// shared types and constants for the power-law damper force pipeline
// no dependencies

package pldf_pkg;

    localparam int LOG_FRAC = 40;
    localparam int LV_W     = 46;
    localparam int Y_W      = 63;
    localparam int Y_FRAC   = 52;
    localparam int EXP_FRAC = 12;
    localparam int MAG_W    = 47;
    localparam int SERIES_N = 31;

    localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AB;
    localparam logic [32:0] MAG_CAP  = 33'h1_0000_0000;
    localparam logic [32:0] POS_LIM  = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NEG_LIM  = 33'h0_8000_0000;
    localparam logic [15:0] ONE_Q12  = 16'd4096;

    localparam logic REG_COEFF = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    typedef struct packed {
        logic neg_r;
        logic xzero;
    } t_tag;

endpackage

### design/power_law_damper_force.sv
// top level of the power-law damper: apb registers, log2 and power pipelines, result packing
// depends on pldf_pkg, pldf_log, pldf_pow

// Evaluates force = sign(rate)*C*|rate|^alpha and tangent = alpha*C*max(|rate|,1 lsb)^(alpha-1)
// on Q16.16 data, with alpha in unsigned Q3.12, both results rounded and saturated to 32 bits.
// One transaction is taken every cycle while the output is not stalled; each result passes
// through the 40-step log2 squaring chain (two stages per bit) and the 31-term
// exponential series (four stages for each term after the first). The whole pipeline holds
// while a finished result waits at the output. Registers: damping_coeff at 0x0,
// power_exponent at 0x4.

module power_law_damper_force import pldf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_strain_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_damper_force,
    output logic signed [31:0] o_damp_tangent,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_coeff;
    logic [14:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= 32'd65536;
            r_alpha <= 15'd4096;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_COEFF: r_coeff <= pwdata;
                REG_ALPHA: r_alpha <= pwdata[14:0];
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALPHA) ? {17'd0, r_alpha} : r_coeff;

    logic r_ov;
    logic en;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    // input magnitude
    logic [31:0] x_in;
    t_tag        tag_in;

    always_comb begin
        x_in         = i_strain_rate[31] ? (32'd0 - i_strain_rate) : i_strain_rate;
        tag_in.neg_r = i_strain_rate[31];
        tag_in.xzero = (x_in == 32'd0);
    end

    logic                   lg_v;
    logic signed [LV_W-1:0] lg_lv;
    t_tag                   lg_tg;

    pldf_log #(
        .FRAC_BITS (FRAC_BITS)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (x_in),
        .i_tag   (tag_in),
        .o_valid (lg_v),
        .o_lv    (lg_lv),
        .o_tag   (lg_tg)
    );

    // exponents and scale magnitudes
    logic signed [15:0]    a_s, e_s;
    logic signed [Y_W-1:0] y_f, y_t;
    logic [31:0]           mag_c;
    logic [MAG_W-1:0]      mag_t;

    always_comb begin
        a_s   = signed'({1'b0, r_alpha});
        e_s   = a_s - signed'(ONE_Q12);
        y_f   = Y_W'(a_s) * Y_W'(lg_lv);
        y_t   = Y_W'(e_s) * Y_W'(lg_lv);
        mag_c = r_coeff[31] ? (32'd0 - r_coeff) : r_coeff;
        mag_t = {15'd0, mag_c} * {32'd0, r_alpha};
    end

    logic signed [Y_W-1:0] r_yf, r_yt;
    logic [MAG_W-1:0]      r_mc, r_mt;
    t_tag                  r_tg;
    logic                  r_yv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv <= 1'b0;
        end else if (en) begin
            r_yv <= lg_v;
        end
        if (en) begin
            r_yf <= y_f;
            r_yt <= y_t;
            r_mc <= {15'd0, mag_c};
            r_mt <= mag_t;
            r_tg <= lg_tg;
        end
    end

    logic [32:0] pf_mag, pt_mag;
    logic        pw_v;
    t_tag        pw_tg;

    pldf_pow #(
        .EXTRA (0)
    ) u_pow_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_yv),
        .i_y     (r_yf),
        .i_mag   (r_mc),
        .i_tag   (r_tg),
        .o_valid (pw_v),
        .o_mag   (pf_mag),
        .o_tag   (pw_tg)
    );

    pldf_pow #(
        .EXTRA (EXP_FRAC)
    ) u_pow_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_yv),
        .i_y     (r_yt),
        .i_mag   (r_mt),
        .i_tag   (r_tg),
        .o_valid (),
        .o_mag   (pt_mag),
        .o_tag   ()
    );

    // sign and saturation
    logic        neg_f, neg_t, sat_f, sat_t;
    logic [32:0] lim_f, lim_t, mf, mt;
    logic [31:0] n_force, n_tan;

    always_comb begin
        neg_f = pw_tg.neg_r ^ r_coeff[31];
        lim_f = neg_f ? NEG_LIM : POS_LIM;
        sat_f = 1'b0;
        mf    = pf_mag;
        if (pf_mag > lim_f) begin
            mf    = lim_f;
            sat_f = 1'b1;
        end
        if (pw_tg.xzero) begin
            n_force = (r_alpha == 15'd0) ? r_coeff : 32'd0;
            sat_f   = 1'b0;
        end else begin
            n_force = neg_f ? (32'd0 - mf[31:0]) : mf[31:0];
        end

        neg_t = r_coeff[31] && (pt_mag != 33'd0);
        lim_t = neg_t ? NEG_LIM : POS_LIM;
        sat_t = 1'b0;
        mt    = pt_mag;
        if (pt_mag > lim_t) begin
            mt    = lim_t;
            sat_t = 1'b1;
        end
        n_tan = neg_t ? (32'd0 - mt[31:0]) : mt[31:0];
    end

    logic [31:0] r_force, r_tan;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= pw_v;
        end
        if (en) begin
            r_force <= n_force;
            r_tan   <= n_tan;
            r_sat   <= sat_f || sat_t;
        end
    end

    assign o_valid        = r_ov;
    assign o_damper_force = r_force;
    assign o_damp_tangent = r_tan;
    assign o_saturated    = r_sat;

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_damper_force == 32'sh7FFFFFFF) || (o_damper_force == 32'sh80000000) ||
            (o_damp_tangent == 32'sh7FFFFFFF) || (o_damp_tangent == 32'sh80000000))
        else $error("saturation flag without a clipped result");

    a_tan_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_coeff[31] |-> !o_damp_tangent[31])
        else $error("negative tangent with a positive coefficient");

    a_tan_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_alpha == 15'd0) |-> (o_damp_tangent == 32'sd0))
        else $error("nonzero tangent with zero exponent");

endmodule

### design/pldf_log.sv
// pipelined log2 of an unsigned fixed-point magnitude, one fraction bit per squaring
// depends on pldf_pkg

module pldf_log import pldf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [31:0]            i_x,
    input  t_tag                   i_tag,
    output logic                   o_valid,
    output logic signed [LV_W-1:0] o_lv,
    output t_tag                   o_tag
);

    logic [31:0]       xx;
    logic [4:0]        msb;
    logic [61:0]       z0;
    logic signed [5:0] e0;

    always_comb begin
        xx  = (i_x == 32'd0) ? 32'd1 : i_x;
        msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (xx[b]) begin
                msb = 5'(b);
            end
        end
        z0 = {30'd0, xx} << (6'd61 - {1'b0, msb});
        e0 = 6'({1'b0, msb}) - 6'(FRAC_BITS);
    end

    logic [61:0]          r_z  [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]  r_fr [0:LOG_FRAC];
    logic signed [5:0]    r_e  [0:LOG_FRAC];
    t_tag                 r_tg [0:LOG_FRAC];
    logic                 r_vb [0:LOG_FRAC];

    logic [61:0]          r_aa [0:LOG_FRAC-1];
    logic [61:0]          r_ab [0:LOG_FRAC-1];
    logic [61:0]          r_bb [0:LOG_FRAC-1];
    logic [LOG_FRAC-1:0]  r_fa [0:LOG_FRAC-1];
    logic signed [5:0]    r_ea [0:LOG_FRAC-1];
    t_tag                 r_ta [0:LOG_FRAC-1];
    logic                 r_va [0:LOG_FRAC-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb[0] <= 1'b0;
        end else if (i_en) begin
            r_vb[0] <= i_valid;
        end
        if (i_en) begin
            r_z[0]  <= z0;
            r_fr[0] <= '0;
            r_e[0]  <= e0;
            r_tg[0] <= i_tag;
        end
    end

    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
        logic [123:0] p;
        logic [62:0]  zs;
        logic [61:0]  n_z;
        logic         n_bit;

        // square partial products
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[g] <= 1'b0;
            end else if (i_en) begin
                r_va[g] <= r_vb[g];
            end
            if (i_en) begin
                r_aa[g] <= {31'd0, r_z[g][61:31]} * {31'd0, r_z[g][61:31]};
                r_ab[g] <= {31'd0, r_z[g][61:31]} * {31'd0, r_z[g][30:0]};
                r_bb[g] <= {31'd0, r_z[g][30:0]} * {31'd0, r_z[g][30:0]};
                r_fa[g] <= r_fr[g];
                r_ea[g] <= r_e[g];
                r_ta[g] <= r_tg[g];
            end
        end

        always_comb begin
            p     = {r_aa[g], 62'd0} + {30'd0, r_ab[g], 32'd0} + {62'd0, r_bb[g]};
            zs    = p[123:61];
            n_bit = zs[62];
            n_z   = n_bit ? zs[62:1] : zs[61:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vb[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vb[g+1] <= r_va[g];
            end
            if (i_en) begin
                r_z[g+1]  <= n_z;
                r_fr[g+1] <= {r_fa[g][LOG_FRAC-2:0], n_bit};
                r_e[g+1]  <= r_ea[g];
                r_tg[g+1] <= r_ta[g];
            end
        end
    end

    assign o_valid = r_vb[LOG_FRAC];
    assign o_lv    = {r_e[LOG_FRAC], r_fr[LOG_FRAC]};
    assign o_tag   = r_tg[LOG_FRAC];

endmodule

### design/pldf_pow.sv
// pipelined mag * 2^(y / 2^52) / 2^EXTRA, rounded and capped, via an exp series
// depends on pldf_pkg

module pldf_pow import pldf_pkg::*; #(
    parameter int EXTRA = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [Y_W-1:0] i_y,
    input  logic [MAG_W-1:0]      i_mag,
    input  t_tag                  i_tag,
    output logic                  o_valid,
    output logic [32:0]           o_mag,
    output t_tag                  o_tag
);

    localparam int NIT = SERIES_N - 1;

    typedef struct packed {
        logic signed [10:0] k;
        logic [MAG_W-1:0]   mag;
        logic [61:0]        t;
        logic [62:0]        sum;
        t_tag               tag;
    } t_carry;

    // split y into integer and fraction
    logic signed [10:0] r0_k;
    logic [61:0]        r0_f;
    logic [MAG_W-1:0]   r0_mag;
    t_tag               r0_tg;
    logic               r0_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
        if (i_en) begin
            r0_k   <= i_y[Y_W-1:Y_FRAC];
            r0_f   <= {i_y[Y_FRAC-1:0], 10'd0};
            r0_mag <= i_mag;
            r0_tg  <= i_tag;
        end
    end

    // fraction times ln2
    logic [62:0]        r1_hh, r1_hl, r1_lh, r1_ll;
    logic signed [10:0] r1_k;
    logic [MAG_W-1:0]   r1_mag;
    t_tag               r1_tg;
    logic               r1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
        if (i_en) begin
            r1_hh  <= {32'd0, r0_f[61:31]} * {31'd0, LN2_Q64[63:32]};
            r1_hl  <= {32'd0, r0_f[61:31]} * {31'd0, LN2_Q64[31:0]};
            r1_lh  <= {32'd0, r0_f[30:0]} * {31'd0, LN2_Q64[63:32]};
            r1_ll  <= {32'd0, r0_f[30:0]} * {31'd0, LN2_Q64[31:0]};
            r1_k   <= r0_k;
            r1_mag <= r0_mag;
            r1_tg  <= r0_tg;
        end
    end

    logic [125:0] p2;
    logic [61:0]  t2;

    always_comb begin
        p2 = {r1_hh, 63'd0} + {32'd0, r1_hl, 31'd0} + {31'd0, r1_lh, 32'd0}
           + {63'd0, r1_ll};
        t2 = p2[125:64] + {61'd0, p2[63]};
    end

    t_carry      r_cd   [0:NIT];
    logic [61:0] r_term [0:NIT];
    logic        r_vd   [0:NIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (i_en) begin
            r_vd[0] <= r1_v;
        end
        if (i_en) begin
            r_cd[0]   <= '{k: r1_k, mag: r1_mag, t: t2,
                           sum: {1'b1, 62'd0} + {1'b0, t2}, tag: r1_tg};
            r_term[0] <= t2;
        end
    end

    t_carry      r_ca  [0:NIT-1];
    t_carry      r_cb  [0:NIT-1];
    t_carry      r_cc  [0:NIT-1];
    logic        r_va  [0:NIT-1];
    logic        r_vb  [0:NIT-1];
    logic        r_vc  [0:NIT-1];
    logic [61:0] r_phh [0:NIT-1];
    logic [61:0] r_phl [0:NIT-1];
    logic [61:0] r_plh [0:NIT-1];
    logic [61:0] r_pll [0:NIT-1];
    logic [61:0] r_w   [0:NIT-1];
    logic [62:0] r_qhh [0:NIT-1];
    logic [62:0] r_qhl [0:NIT-1];
    logic [62:0] r_qlh [0:NIT-1];
    logic [62:0] r_qll [0:NIT-1];

    for (genvar g = 0; g < NIT; g++) begin : g_term
        localparam int           L  = $clog2(g + 2);
        localparam logic [127:0] MW = ((128'd1 << (62 + L)) + 128'(g + 1)) / 128'(g + 2);
        localparam logic [62:0]  M  = MW[62:0];

        logic [123:0] pb;
        logic [124:0] pd;
        logic [61:0]  q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[g] <= 1'b0;
                r_vb[g] <= 1'b0;
                r_vc[g] <= 1'b0;
            end else if (i_en) begin
                r_va[g] <= r_vd[g];
                r_vb[g] <= r_va[g];
                r_vc[g] <= r_vb[g];
            end
            if (i_en) begin
                r_phh[g] <= {31'd0, r_term[g][61:31]} * {31'd0, r_cd[g].t[61:31]};
                r_phl[g] <= {31'd0, r_term[g][61:31]} * {31'd0, r_cd[g].t[30:0]};
                r_plh[g] <= {31'd0, r_term[g][30:0]} * {31'd0, r_cd[g].t[61:31]};
                r_pll[g] <= {31'd0, r_term[g][30:0]} * {31'd0, r_cd[g].t[30:0]};
                r_ca[g]  <= r_cd[g];
                r_w[g]   <= pb[123:62];
                r_cb[g]  <= r_ca[g];
                r_qhh[g] <= {32'd0, r_w[g][61:31]} * {31'd0, M[62:31]};
                r_qhl[g] <= {32'd0, r_w[g][61:31]} * {32'd0, M[30:0]};
                r_qlh[g] <= {32'd0, r_w[g][30:0]} * {31'd0, M[62:31]};
                r_qll[g] <= {32'd0, r_w[g][30:0]} * {32'd0, M[30:0]};
                r_cc[g]  <= r_cb[g];
            end
        end

        always_comb begin
            pb = {r_phh[g], 62'd0} + {31'd0, r_phl[g], 31'd0} + {31'd0, r_plh[g], 31'd0}
               + {62'd0, r_pll[g]};
            pd = {r_qhh[g], 62'd0} + {31'd0, r_qhl[g], 31'd0} + {31'd0, r_qlh[g], 31'd0}
               + {62'd0, r_qll[g]};
            q  = 62'(pd >> (62 + L));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vd[g+1] <= r_vc[g];
            end
            if (i_en) begin
                r_term[g+1] <= q;
                r_cd[g+1]   <= '{k: r_cc[g].k, mag: r_cc[g].mag, t: r_cc[g].t,
                                 sum: r_cc[g].sum + {1'b0, q}, tag: r_cc[g].tag};
            end
        end
    end

    // mag times series sum
    logic [63:0]        re_hh, re_hl, re_lh, re_ll;
    logic signed [10:0] re_k;
    logic               re_mz;
    t_tag               re_tg;
    logic               re_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_v <= 1'b0;
        end else if (i_en) begin
            re_v <= r_vd[NIT];
        end
        if (i_en) begin
            re_hh <= {49'd0, r_cd[NIT].mag[46:32]} * {33'd0, r_cd[NIT].sum[62:32]};
            re_hl <= {49'd0, r_cd[NIT].mag[46:32]} * {32'd0, r_cd[NIT].sum[31:0]};
            re_lh <= {32'd0, r_cd[NIT].mag[31:0]} * {33'd0, r_cd[NIT].sum[62:32]};
            re_ll <= {32'd0, r_cd[NIT].mag[31:0]} * {32'd0, r_cd[NIT].sum[31:0]};
            re_k  <= r_cd[NIT].k;
            re_mz <= (r_cd[NIT].mag == '0);
            re_tg <= r_cd[NIT].tag;
        end
    end

    // rounding offset and shift amount
    logic [127:0]       pf;
    logic signed [11:0] sv;
    logic               f_cap, f_zero;
    logic [127:0]       half;

    always_comb begin
        pf     = {re_hh, 64'd0} + {32'd0, re_hl, 32'd0} + {32'd0, re_lh, 32'd0}
               + {64'd0, re_ll};
        sv     = 12'(62 + EXTRA) - {re_k[10], re_k};
        f_zero = re_mz || (sv >= 12'sd128);
        f_cap  = !f_zero && (sv <= 12'sd0);
        half   = (f_zero || f_cap) ? 128'd0 : (128'd1 << (sv[6:0] - 7'd1));
    end

    logic [127:0] rf_pr;
    logic [6:0]   rf_sh;
    logic         rf_cap, rf_zero;
    t_tag         rf_tg;
    logic         rf_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_v <= 1'b0;
        end else if (i_en) begin
            rf_v <= re_v;
        end
        if (i_en) begin
            rf_pr   <= pf + half;
            rf_sh   <= sv[6:0];
            rf_cap  <= f_cap;
            rf_zero <= f_zero;
            rf_tg   <= re_tg;
        end
    end

    logic [127:0] rs;
    logic [32:0]  n_mag;

    always_comb begin
        rs = rf_pr >> rf_sh;
        priority if (rf_zero) begin
            n_mag = '0;
        end else if (rf_cap || rs[127:33] != '0 || rs[32:0] > MAG_CAP) begin
            n_mag = MAG_CAP;
        end else begin
            n_mag = rs[32:0];
        end
    end

    logic [32:0] r_mag;
    t_tag        r_tg;
    logic        r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= rf_v;
        end
        if (i_en) begin
            r_mag <= n_mag;
            r_tg  <= rf_tg;
        end
    end

    assign o_valid = r_v;
    assign o_mag   = r_mag;
    assign o_tag   = r_tg;

endmodule
